@@ rtl/swdc_pkg.sv @@
package swdc_pkg;

    localparam int VALUE_BITS     = 8;
    localparam int WS_W           = 7;
    localparam int DC_W           = 7;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int OUT_DEPTH      = 4;

    localparam logic [WS_W-1:0] WS_RESET = 7'd4;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last_item;
    } swdc_in_t;

    typedef struct packed {
        logic [DC_W-1:0] distinct_count;
        logic            last_window;
    } swdc_out_t;

endpackage

@@ rtl/swdc_ram.sv @@
module swdc_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents when the write hits the same entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/swdc_out_fifo.sv @@
module swdc_out_fifo #(
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  swdc_pkg::swdc_out_t push_data,
    input  logic                pop,
    output logic                out_valid,
    output swdc_pkg::swdc_out_t out_data,
    output logic [CNT_W-1:0]    count
);
    import swdc_pkg::*;

    swdc_out_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/sliding_window_distinct_count.sv @@
// Sliding-window distinct-value counter.
// s_ channel: one array element per request (value, last_item flag).
// m_ channel: one result per full window (distinct_count, last_window).
// cfg_wr_en/cfg_wr_data write window_size at once; a write also drops the
// array in progress. Write it only while no request is in flight.
// A new request is held off while the one before it is still in s1; the
// occurrence-count memory does two read-modify-writes per request (leaving
// value, entering value) through its single read and single write port.
// A result passes through stages s1, s2 and s3 and is then queued.
// Results queue in a 4-entry output buffer; when the receiver stalls,
// s_ready drops once the buffer cannot take the requests in flight.
// Reset: every one of the 2^VALUE_BITS (256) count memory entries is swept
// to zero with s_ready low. After a config write, the counts of the values
// still in the window are zeroed, one per cycle, with s_ready low; after a
// last_item request the same clear starts once that request has left
// stages s1, s2 and s3.
module sliding_window_distinct_count #(
    parameter int WINDOW_MAX = swdc_pkg::WINDOW_MAX_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  swdc_pkg::swdc_in_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output swdc_pkg::swdc_out_t       m_data,
    input  logic                      cfg_wr_en,
    input  logic [swdc_pkg::WS_W-1:0] cfg_wr_data
);
    import swdc_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int PW     = $clog2(WINDOW_MAX);
    localparam int KW     = (CNT_W > WS_W) ? CNT_W : WS_W;
    localparam int PK     = CNT_W + 1;
    localparam int VDEPTH = 1 << VALUE_BITS;
    localparam int FC_W   = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        logic                  evict;
        logic                  emit;
    } stage_t;

    // control state
    logic [WS_W-1:0]       ws_reg, ws_next;
    logic [PW-1:0]         wp_reg, wp_next;
    logic [CNT_W-1:0]      items_seen_reg, items_seen_next;
    logic [CNT_W-1:0]      distinct_reg, distinct_next;
    logic                  pending_reg, pending_next;
    logic                  drain_active_reg, drain_active_next;
    logic                  drain_wr_reg;
    logic [CNT_W-1:0]      drain_left_reg, drain_left_next;
    logic [PW-1:0]         drain_pos_reg, drain_pos_next;
    logic                  sweep_reg, sweep_next;
    logic [VALUE_BITS-1:0] sweep_addr_reg, sweep_addr_next;
    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                  fwd_hit_reg;

    // payload registers
    stage_t                s1_reg, s2_reg, s3_reg;
    logic [VALUE_BITS-1:0] s2_old_reg;
    logic [CNT_W-1:0]      fwd_data_reg;

    logic [KW-1:0]         ws_ext, k_full;
    logic [CNT_W-1:0]      k;
    logic [PK-1:0]         wp_w, k_w, old_w;
    logic [PW-1:0]         old_pos, wp_dec, drain_pos_dec;
    logic                  is_evict, is_emit;
    logic                  acc, pipe_empty, drain_start, credit_ok;
    logic [FC_W:0]         in_flight;
    logic [FC_W-1:0]       fifo_count;

    logic [PW-1:0]         rec_raddr;
    logic [VALUE_BITS-1:0] recent_rd;

    logic                  cnt_we;
    logic [VALUE_BITS-1:0] cnt_wa, cnt_ra;
    logic [CNT_W-1:0]      cnt_wd, cnt_q, cnt_rd;
    logic                  dec, inc;

    logic                  push;
    swdc_out_t             push_data;

    // active window size: zero acts as one, clamped to the store depth
    assign ws_ext = KW'(ws_reg);
    always_comb begin
        if (ws_ext == '0) begin
            k_full = KW'(1);
        end else if (ws_ext > KW'(WINDOW_MAX)) begin
            k_full = KW'(WINDOW_MAX);
        end else begin
            k_full = ws_ext;
        end
    end
    assign k = CNT_W'(k_full);

    // position of the element that leaves the window
    assign wp_w    = PK'(wp_reg);
    assign k_w     = PK'(k);
    assign old_w   = (wp_w >= k_w) ? wp_w - k_w : wp_w + PK'(WINDOW_MAX) - k_w;
    assign old_pos = PW'(old_w);

    assign wp_dec        = (wp_reg == '0) ? PW'(WINDOW_MAX - 1) : wp_reg - 1'b1;
    assign drain_pos_dec = (drain_pos_reg == '0) ? PW'(WINDOW_MAX - 1) : drain_pos_reg - 1'b1;

    assign is_evict = (items_seen_reg >= k);
    assign is_emit  = ((PK'(items_seen_reg) + PK'(1)) >= k_w);

    assign pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign in_flight  = (FC_W + 1)'(fifo_count) + (FC_W + 1)'(s2_valid_reg)
                      + (FC_W + 1)'(s3_valid_reg);
    assign credit_ok  = (in_flight < (FC_W + 1)'(OUT_DEPTH));

    // a new request only when s1 is empty, leaving the count read port free
    assign s_ready = !s1_valid_reg && !sweep_reg && !pending_reg && !drain_active_reg
                   && !drain_wr_reg && credit_ok;
    assign acc     = s_valid && s_ready;

    assign drain_start = pending_reg && !sweep_reg && !drain_active_reg && !drain_wr_reg
                       && pipe_empty;

    // recent-value store
    assign rec_raddr = drain_active_reg ? drain_pos_reg : old_pos;

    swdc_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (VALUE_BITS)
    ) u_recent (
        .aclk  (aclk),
        .we    (acc),
        .waddr (wp_reg),
        .wdata (s_data.value),
        .raddr (rec_raddr),
        .rdata (recent_rd)
    );

    // occurrence-count memory with write-to-read forwarding
    assign cnt_ra = s2_valid_reg ? s2_reg.value : recent_rd;
    assign cnt_rd = fwd_hit_reg ? fwd_data_reg : cnt_q;

    always_comb begin
        cnt_we = 1'b0;
        cnt_wa = sweep_addr_reg;
        cnt_wd = '0;
        priority if (sweep_reg) begin
            cnt_we = 1'b1;
        end else if (drain_wr_reg) begin
            cnt_we = 1'b1;
            cnt_wa = recent_rd;
        end else if (s3_valid_reg) begin
            cnt_we = 1'b1;
            cnt_wa = s3_reg.value;
            cnt_wd = cnt_rd + 1'b1;
        end else if (s2_valid_reg && s2_reg.evict && (cnt_rd != '0)) begin
            cnt_we = 1'b1;
            cnt_wa = s2_old_reg;
            cnt_wd = cnt_rd - 1'b1;
        end
    end

    swdc_ram #(
        .DEPTH (VDEPTH),
        .WIDTH (CNT_W)
    ) u_counts (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_wa),
        .wdata (cnt_wd),
        .raddr (cnt_ra),
        .rdata (cnt_q)
    );

    // leaving value dropped to zero, entering value was absent
    assign dec = s2_valid_reg && s2_reg.evict && (cnt_rd == CNT_W'(1)) && (distinct_reg != '0);
    assign inc = s3_valid_reg && (cnt_rd == '0);

    always_comb begin
        ws_next           = ws_reg;
        wp_next           = wp_reg;
        items_seen_next   = items_seen_reg;
        distinct_next     = distinct_reg - CNT_W'(dec) + CNT_W'(inc);
        pending_next      = pending_reg;
        drain_active_next = drain_active_reg;
        drain_left_next   = drain_left_reg;
        drain_pos_next    = drain_pos_reg;
        sweep_next        = sweep_reg;
        sweep_addr_next   = sweep_addr_reg;

        if (acc) begin
            wp_next = (wp_reg == PW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
            if (!is_evict) begin
                items_seen_next = items_seen_reg + 1'b1;
            end
            if (s_data.last_item) begin
                pending_next = 1'b1;
            end
        end

        // walk back over the window and zero its counts
        if (drain_start) begin
            pending_next      = 1'b0;
            wp_next           = '0;
            items_seen_next   = '0;
            distinct_next     = '0;
            drain_left_next   = items_seen_reg;
            drain_pos_next    = wp_dec;
            drain_active_next = (items_seen_reg != '0);
        end

        if (drain_active_reg) begin
            drain_left_next = drain_left_reg - 1'b1;
            drain_pos_next  = drain_pos_dec;
            if (drain_left_reg == CNT_W'(1)) begin
                drain_active_next = 1'b0;
            end
        end

        if (sweep_reg) begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == '1) begin
                sweep_next = 1'b0;
            end
        end

        if (cfg_wr_en) begin
            ws_next      = cfg_wr_data;
            pending_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg           <= WS_RESET;
            wp_reg           <= '0;
            items_seen_reg   <= '0;
            distinct_reg     <= '0;
            pending_reg      <= 1'b0;
            drain_active_reg <= 1'b0;
            drain_wr_reg     <= 1'b0;
            drain_left_reg   <= '0;
            drain_pos_reg    <= '0;
            sweep_reg        <= 1'b1;
            sweep_addr_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
        end else begin
            ws_reg           <= ws_next;
            wp_reg           <= wp_next;
            items_seen_reg   <= items_seen_next;
            distinct_reg     <= distinct_next;
            pending_reg      <= pending_next;
            drain_active_reg <= drain_active_next;
            drain_wr_reg     <= drain_active_reg;
            drain_left_reg   <= drain_left_next;
            drain_pos_reg    <= drain_pos_next;
            sweep_reg        <= sweep_next;
            sweep_addr_reg   <= sweep_addr_next;
            s1_valid_reg     <= acc;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            fwd_hit_reg      <= cnt_we && (cnt_wa == cnt_ra);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_reg.value <= s_data.value;
            s1_reg.last  <= s_data.last_item;
            s1_reg.evict <= is_evict;
            s1_reg.emit  <= is_emit;
        end
        s2_reg       <= s1_reg;
        s2_old_reg   <= recent_rd;
        s3_reg       <= s2_reg;
        fwd_data_reg <= cnt_wd;
    end

    // result queue
    assign push                     = s3_valid_reg && s3_reg.emit;
    assign push_data.distinct_count = DC_W'(distinct_reg + CNT_W'(inc));
    assign push_data.last_window    = s3_reg.last;

    swdc_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_data  (m_data),
        .count     (fifo_count)
    );

    a_stage_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s1_valid_reg && s2_valid_reg))
        else $error("requests closer than two cycles in the count pipeline");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_count < FC_W'(OUT_DEPTH)))
        else $error("result queue overflow");

    a_drain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_wr_reg || drain_active_reg) |-> (pipe_empty && !acc))
        else $error("window clear overlaps a request in flight");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.distinct_count != '0))
        else $error("full window reported with no distinct values");

endmodule

@@ test/sliding_window_distinct_count_tb.sv @@
module sliding_window_distinct_count_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swdc_pkg::*;

    localparam int SPAN_MAX   = WINDOW_MAX_DEF;
    localparam int CYCLE_CAP  = 1000000;
    localparam int SETTLE     = 80;
    localparam int LONG_HOLD  = 400;
    localparam int PHASE_LEN  = 85;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    swdc_in_t          s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    swdc_out_t         m_data;
    logic              cfg_wr_en   = 1'b0;
    logic [WS_W-1:0]   cfg_wr_data = '0;

    // element stream waiting for the driver, and window counts still owed
    swdc_in_t  element_q[$];
    swdc_out_t distinct_q[$];

    int unsigned issued      = 0;
    int unsigned accepted    = 0;
    int unsigned errors      = 0;
    int unsigned cycles      = 0;
    int unsigned gap_odds    = 0;
    int unsigned stall_odds  = 0;
    int unsigned hold_asks   = 0;
    int unsigned hold_served = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    int unsigned hold_left   = 0;

    // model state of the window logic
    logic [VALUE_BITS-1:0] window_vals [SPAN_MAX];
    int unsigned           hits [2**VALUE_BITS];
    logic [5:0]            slot;
    int unsigned           fill;
    int unsigned           n_distinct;
    logic [WS_W-1:0]       win_len;

    sliding_window_distinct_count u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_counts();
        foreach (hits[i]) hits[i] = 0;
        slot       = '0;
        fill       = 0;
        n_distinct = 0;
    endfunction

    function automatic int unsigned active_span();
        if (win_len == 0) return 1;
        if (win_len > SPAN_MAX) return SPAN_MAX;
        return win_len;
    endfunction

    function automatic void advance_window(swdc_in_t req);
        int unsigned           k;
        logic [5:0]            old_slot;
        logic [VALUE_BITS-1:0] old_val;
        swdc_out_t             res;
        k = active_span();
        // value falling out of the window
        if (fill >= k) begin
            old_slot = slot - 6'(k);
            old_val  = window_vals[old_slot];
            if (hits[old_val] > 0) begin
                hits[old_val]--;
                if (hits[old_val] == 0 && n_distinct > 0) n_distinct--;
            end
        end
        if (hits[req.value] == 0) n_distinct++;
        hits[req.value]++;
        window_vals[slot] = req.value;
        slot++;
        if (fill < k) fill++;
        if (fill >= k) begin
            res.distinct_count = DC_W'(n_distinct);
            res.last_window    = req.last_item;
            distinct_q = {distinct_q, res};
        end
        if (req.last_item) clear_counts();
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_window(s_data);
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid <= 1'b0;
                    gap_left--;
                end else if (element_q.size() > 0) begin
                    s_data  <= element_q.pop_front();
                    s_valid <= 1'b1;
                    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                        gap_left = $urandom_range(1, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        swdc_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (distinct_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: count %0d last %0b",
                                 m_data.distinct_count, m_data.last_window);
                end else begin
                    want = distinct_q.pop_front();
                    if (m_data.distinct_count !== want.distinct_count ||
                        m_data.last_window !== want.last_window) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: count exp %0d got %0d, last exp %0b got %0b",
                                     want.distinct_count, m_data.distinct_count,
                                     want.last_window, m_data.last_window);
                    end
                end
            end
            if (hold_asks != hold_served) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_elem(input logic [VALUE_BITS-1:0] v, input logic l);
        swdc_in_t req;
        req.value     = v;
        req.last_item = l;
        element_q = {element_q, req};
        issued++;
    endtask

    task automatic drain();
        while (!(accepted == issued && distinct_q.size() == 0))
            @(negedge aclk);
        // leaves time for the count clear after a closing request
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_window(input logic [WS_W-1:0] ws);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ws;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_len = ws;
        clear_counts();
        @(negedge aclk);
    endtask

    task automatic push_array(input int unsigned len, input bit close);
        int unsigned           span;
        logic [VALUE_BITS-1:0] base;
        case ($urandom_range(0, 4))
            0:       span = 2;
            1:       span = 4;
            2:       span = 8;
            3:       span = active_span();
            default: span = 256;
        endcase
        base = $urandom_range(0, 255);
        for (int unsigned i = 0; i < len; i++)
            push_elem(VALUE_BITS'(base + $urandom_range(0, span - 1)), close && i == len - 1);
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned k;
        int unsigned len;
        int unsigned sent;
        k    = active_span();
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, k);
            else
                len = k + $urandom_range(0, 24);
            push_array(len, 1'b1);
            sent += len;
        end
        // sometimes leave an array open for the next window write to drop
        if ($urandom_range(0, 2) == 0)
            push_array($urandom_range(1, k + 5), 1'b0);
    endtask

    initial begin
        logic [WS_W-1:0] ws_list [15];
        int unsigned     pick;

        ws_list = '{7'd1, 7'd64, 7'd2, 7'd0, 7'd127, 7'd3, 7'd16, 7'd65,
                    7'd8, 7'd5, 7'd33, 7'd0, 7'd0, 7'd0, 7'd4};
        for (int i = 11; i < 14; i++) ws_list[i] = WS_W'($urandom_range(1, 64));

        win_len = WS_RESET;
        clear_counts();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset window size
        gap_odds   = 4;
        stall_odds = 4;
        for (int i = 0; i < 4; i++) push_elem(8'd0, i == 3);
        for (int i = 0; i < 6; i++) push_elem(8'(255 - i), i == 5);
        push_elem(8'd7, 1'b0);
        push_elem(8'd8, 1'b1);
        push_elem(8'd1, 1'b0);
        push_elem(8'd2, 1'b0);
        push_elem(8'd1, 1'b0);
        push_elem(8'd2, 1'b0);
        for (int i = 0; i < 4; i++) push_elem(8'd3, i == 3);
        for (int i = 0; i < 4; i++) push_elem(8'(10 * (i + 1)), i == 3);
        drain();

        for (int p = 0; p < 15; p++) begin
            write_window(ws_list[p]);
            if (p == 6) begin
                // receiver holds off while requests keep coming
                gap_odds   = 0;
                stall_odds = 0;
                hold_asks++;
            end else if (p == 14) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                pick       = $urandom_range(0, 2);
                gap_odds   = (pick == 0) ? 0 : (pick == 1) ? 3 : 10;
                pick       = $urandom_range(0, 2);
                stall_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 10;
            end
            random_phase(PHASE_LEN);
            drain();
        end

        if (distinct_q.size() != 0) errors++;
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sliding_window_distinct_count.f @@
rtl/swdc_pkg.sv
rtl/swdc_ram.sv
rtl/swdc_out_fifo.sv
rtl/sliding_window_distinct_count.sv
test/sliding_window_distinct_count_tb.sv
